>>> rtl/stepper_proportional_step_generator_unit_assert.svh
// assertion macros shared by the checker of the step generator
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef STEPPER_PROPORTIONAL_STEP_GENERATOR_UNIT_ASSERT_SVH
`define STEPPER_PROPORTIONAL_STEP_GENERATOR_UNIT_ASSERT_SVH

// consequent checked in the cycle after the antecedent
`define SPG_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spg: next-cycle check failed");

// consequent checked in the same cycle as the antecedent
`define SPG_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spg: same-cycle check failed");

`endif

>>> rtl/spg_pkg.sv
// types and constants of the proportional step generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package spg_pkg;

   // field widths
   localparam int POS_W   = 14;
   localparam int TGT_W   = 15;
   localparam int DT_W    = 16;
   localparam int GAIN_W  = 8;
   localparam int RATE_W  = 16;
   localparam int PULSE_W = 8;

   // internal magnitudes
   localparam int EMAG_W  = 15;   // |target - position| and |position + delta|
   localparam int RMAG_W  = 20;   // rate limit in 1/16 steps per second
   localparam int QUOT_W  = 8;    // whole steps kept by the divider
   localparam int DIVR_W  = 24;   // remainder of the step divider

   // accumulator units in one step (1/16 micro-step)
   localparam logic [DIVR_W-1:0] UNITS_PER_STEP = 24'd16000000;

   // control register port
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 16;

   localparam logic [CSR_AW-1:0] CSR_GAIN          = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_MAX_RATE      = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_STEPS_PER_REV = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_MAX_PULSES    = 2'd3;

   localparam logic [GAIN_W-1:0]  GAIN_RST          = 8'd80;
   localparam logic [RATE_W-1:0]  MAX_RATE_RST      = 16'd2000;
   localparam logic [POS_W-1:0]   STEPS_PER_REV_RST = 14'd1600;
   localparam logic [PULSE_W-1:0] MAX_PULSES_RST    = 8'd50;

   typedef struct packed {
      logic signed [TGT_W-1:0] target_position;
      logic [DT_W-1:0]         dt_us;
   } req_type;

   typedef struct packed {
      logic               direction;
      logic [PULSE_W-1:0] pulse_count;
      logic [POS_W-1:0]   position;
   } rsp_type;

   // load and shift strobes of one serial unit
   typedef struct packed {
      logic load;
      logic step;
   } unit_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_RATE,
      ST_SCALE,
      ST_SUM,
      ST_DIV,
      ST_POS,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

>>> rtl/spg_mod_serial.sv
// bit-serial remainder unit: one numerator bit per cycle while step is set, against a 14-bit divisor
// depends on spg_pkg
`timescale 1ns / 1ps
`default_nettype none

module spg_mod_serial
   import spg_pkg::*;
(
   input  logic                clock,
   input  unit_ctrl_type       ctrl,
   input  logic [EMAG_W-1:0]   num,
   input  logic [POS_W-1:0]    den,
   output logic [POS_W-1:0]    rem
);

   logic [EMAG_W-1:0] num_ff, num_in;
   logic [POS_W-1:0]  rem_ff, rem_in;
   logic [POS_W:0]    trial;

   // restoring step: bring in the next numerator bit, subtract when it fits
   always_comb begin
      trial  = {rem_ff, num_ff[EMAG_W-1]};
      num_in = num_ff;
      rem_in = rem_ff;
      if (ctrl.load) begin
         num_in = num;
         rem_in = '0;
      end else if (ctrl.step) begin
         num_in = {num_ff[EMAG_W-2:0], 1'b0};
         if (trial >= {1'b0, den}) begin
            rem_in = POS_W'(trial - {1'b0, den});
         end else begin
            rem_in = trial[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign rem = rem_ff;

endmodule

`default_nettype wire

>>> rtl/spg_mul_serial.sv
// shift-add multiplier: one multiplier bit per cycle while step is set, product shifts right
// depends on spg_pkg
`timescale 1ns / 1ps
`default_nettype none

module spg_mul_serial
   import spg_pkg::*;
#(
   parameter int A_W = 14,
   parameter int B_W = 8
)
(
   input  logic                 clock,
   input  unit_ctrl_type        ctrl,
   input  logic [A_W-1:0]       a,
   input  logic [B_W-1:0]       b,
   output logic [A_W+B_W-1:0]   product
);

   logic [A_W-1:0] a_ff, a_in;
   logic [A_W-1:0] hi_ff, hi_in;
   logic [B_W-1:0] lo_ff, lo_in;
   logic [A_W:0]   partial;

   // add the multiplicand when the low bit is set, then shift the pair right
   always_comb begin
      partial = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      if (ctrl.load) begin
         a_in  = a;
         hi_in = '0;
         lo_in = b;
      end else if (ctrl.step) begin
         hi_in = partial[A_W:1];
         lo_in = {partial[0], lo_ff[B_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign product = {hi_ff, lo_ff};

endmodule

`default_nettype wire

>>> rtl/spg_div_const.sv
// bit-serial divider by the units per step; keeps an 8-bit quotient and an overflow flag
// depends on spg_pkg
`timescale 1ns / 1ps
`default_nettype none

module spg_div_const
   import spg_pkg::*;
#(
   parameter int NUM_W = 40
)
(
   input  logic                clock,
   input  unit_ctrl_type       ctrl,
   input  logic [NUM_W-1:0]    num,
   output logic [QUOT_W-1:0]   quot,
   output logic                quot_ovf,
   output logic [DIVR_W-1:0]   rem
);

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic              ovf_ff, ovf_in;
   logic [DIVR_W:0]   trial;
   logic              fits;

   // one quotient bit per cycle while step is set; bits pushed past the top mark an overflow
   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      fits    = trial >= {1'b0, UNITS_PER_STEP};
      num_in  = num_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      ovf_in  = ovf_ff;
      if (ctrl.load) begin
         num_in  = num;
         rem_in  = '0;
         quot_in = '0;
         ovf_in  = 1'b0;
      end else if (ctrl.step) begin
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         rem_in  = fits ? DIVR_W'(trial - {1'b0, UNITS_PER_STEP}) : trial[DIVR_W-1:0];
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         ovf_in  = ovf_ff | quot_ff[QUOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
   end

   assign quot     = quot_ff;
   assign quot_ovf = ovf_ff;
   assign rem      = rem_ff;

endmodule

`default_nettype wire

>>> rtl/stepper_proportional_step_generator_unit.sv
// a beat is taken in idle and runs through the error, rate, scale, sum, divide, position and output states
// one item at a time: no new beat is taken until the last one has left the output state
// the time goes in bit-serial passes: two 15-bit remainders, an 8-bit and a 16-bit
// multiply and an ACCUM_WIDTH-bit divide by 16,000,000, one bit per cycle each
// the output register frees the sequencer while a result waits to be taken
// reset (synchronous): position and accumulator to zero, registers to defaults, no beat held
`timescale 1ns / 1ps
`default_nettype none

module stepper_proportional_step_generator_unit
   import spg_pkg::*;
#(
   parameter int ACCUM_WIDTH = 40
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  logic [CSR_AW-1:0]   csr_index,
   input  logic [CSR_DW-1:0]   csr_wdata
);

   localparam int PROD_W = RMAG_W + DT_W;
   localparam int SUM_W  = ((ACCUM_WIDTH > PROD_W + 1) ? ACCUM_WIDTH : PROD_W + 1) + 1;
   localparam int CNT_W  = $clog2(ACCUM_WIDTH + 1);

   // control state
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [GAIN_W-1:0]       gain_ff;
   logic [RATE_W-1:0]       max_rate_ff;
   logic [POS_W-1:0]        spr_ff;
   logic [PULSE_W-1:0]      max_pulses_ff;

   // architectural state
   logic [POS_W-1:0]        cur_ff;
   logic [ACCUM_WIDTH-1:0]  acc_ff;

   // per-item working registers
   logic [EMAG_W-1:0]       err_mag_ff;
   logic                    err_neg_ff;
   logic [DT_W-1:0]         dt_ff;
   logic                    rneg_ff;
   logic [ACCUM_WIDTH-1:0]  sum_ff;
   logic                    sneg_ff;
   logic                    vneg_ff;
   logic                    dir_ff;
   logic [PULSE_W-1:0]      pulse_ff;
   rsp_type                 rsp_data_ff;

   // sequencer strobes
   unit_ctrl_type           mod_ctrl, mul1_ctrl, mul2_ctrl, div_ctrl;
   logic [CNT_W-1:0]        stage_len;
   logic                    stage_last;
   logic                    accept;
   logic                    out_free;

   // datapath
   logic [POS_W-1:0]        spr_eff;
   logic signed [TGT_W+1:0] err_raw;
   logic [TGT_W+1:0]        err_abs;
   logic [POS_W-1:0]        mod_rem;
   logic [EMAG_W-1:0]       mod_num;
   logic [POS_W:0]          rem_twice;
   logic                    wrap_over;
   logic [POS_W-1:0]        wrap_mag;
   logic [POS_W+GAIN_W-1:0] mul1_prod;
   logic [RMAG_W-1:0]       rate_lim;
   logic [RMAG_W-1:0]       rate_mag;
   logic [PROD_W-1:0]       mul2_prod;
   logic [SUM_W-1:0]        acc_ext;
   logic [SUM_W-1:0]        prod_ext;
   logic [SUM_W-1:0]        sum_wide;
   logic [SUM_W-ACCUM_WIDTH:0] sum_top;
   logic [ACCUM_WIDTH-1:0]  sum_sat;
   logic [ACCUM_WIDTH-1:0]  sum_mag;
   logic [QUOT_W-1:0]       div_quot;
   logic                    div_ovf;
   logic [DIVR_W-1:0]       div_rem;
   logic [ACCUM_WIDTH-1:0]  rem_ext;
   logic                    steps_nz;
   logic                    dir_new;
   logic [PULSE_W-1:0]      pulse_new;
   logic [POS_W+1:0]        pos_sum;
   logic [POS_W+1:0]        pos_abs;
   logic [POS_W-1:0]        pos_new;

   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a zero revolution behaves as one step
   assign spr_eff = (spr_ff == '0) ? POS_W'(1) : spr_ff;

   // raw error at accept
   always_comb begin
      err_raw = {{2{req_data.target_position[TGT_W-1]}}, req_data.target_position}
              - {3'b000, cur_ff};
      err_abs = err_raw[TGT_W+1] ? -err_raw : err_raw;
   end

   // remainder unit serves the error wrap and the position fold
   assign mod_num = (state_ff == ST_ERR) ? err_mag_ff : pos_abs[EMAG_W-1:0];

   spg_mod_serial u_mod (
      .clock (clock),
      .ctrl  (mod_ctrl),
      .num   (mod_num),
      .den   (spr_eff),
      .rem   (mod_rem)
   );

   // wrap to half a revolution: beyond half, step back by one revolution
   always_comb begin
      rem_twice = {mod_rem, 1'b0};
      wrap_over = rem_twice > {1'b0, spr_eff};
      wrap_mag  = wrap_over ? spr_eff - mod_rem : mod_rem;
   end

   spg_mul_serial #(
      .A_W (POS_W),
      .B_W (GAIN_W)
   ) u_mul_rate (
      .clock   (clock),
      .ctrl    (mul1_ctrl),
      .a       (wrap_mag),
      .b       (gain_ff),
      .product (mul1_prod)
   );

   // rate saturation at max_rate in 1/16 steps per second
   always_comb begin
      rate_lim = {max_rate_ff, 4'b0000};
      rate_mag = (mul1_prod > {{(POS_W+GAIN_W-RMAG_W){1'b0}}, rate_lim})
               ? rate_lim : mul1_prod[RMAG_W-1:0];
   end

   spg_mul_serial #(
      .A_W (RMAG_W),
      .B_W (DT_W)
   ) u_mul_scale (
      .clock   (clock),
      .ctrl    (mul2_ctrl),
      .a       (rate_mag),
      .b       (dt_ff),
      .product (mul2_prod)
   );

   // signed accumulate with saturation to the accumulator range
   always_comb begin
      acc_ext  = {{(SUM_W-ACCUM_WIDTH){acc_ff[ACCUM_WIDTH-1]}}, acc_ff};
      prod_ext = {{(SUM_W-PROD_W){1'b0}}, mul2_prod};
      sum_wide = acc_ext + (prod_ext ^ {SUM_W{rneg_ff}}) + SUM_W'(rneg_ff);
      sum_top  = sum_wide[SUM_W-1:ACCUM_WIDTH-1];
      if ((&sum_top) | ~(|sum_top)) begin
         sum_sat = sum_wide[ACCUM_WIDTH-1:0];
      end else if (sum_wide[SUM_W-1]) begin
         sum_sat = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
      end
      sum_mag = sum_ff[ACCUM_WIDTH-1] ? -sum_ff : sum_ff;
   end

   spg_div_const #(
      .NUM_W (ACCUM_WIDTH)
   ) u_div (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .num      (sum_mag),
      .quot     (div_quot),
      .quot_ovf (div_ovf),
      .rem      (div_rem)
   );

   // whole steps, pulse clamp and the unfolded new position
   always_comb begin
      rem_ext   = {{(ACCUM_WIDTH-DIVR_W){1'b0}}, div_rem};
      steps_nz  = div_ovf | (|div_quot);
      dir_new   = steps_nz & ~sneg_ff;
      pulse_new = (div_ovf || (div_quot > max_pulses_ff)) ? max_pulses_ff : div_quot;
      if (dir_new) begin
         pos_sum = {2'b00, cur_ff} + {{(POS_W+2-PULSE_W){1'b0}}, pulse_new};
      end else begin
         pos_sum = {2'b00, cur_ff} - {{(POS_W+2-PULSE_W){1'b0}}, pulse_new};
      end
      pos_abs = pos_sum[POS_W+1] ? -pos_sum : pos_sum;
      pos_new = (vneg_ff && (mod_rem != '0)) ? spr_eff - mod_rem : mod_rem;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_ERR;
         ST_ERR:   if (stage_last) state_in = ST_RATE;
         ST_RATE:  if (stage_last) state_in = ST_SCALE;
         ST_SCALE: if (stage_last) state_in = ST_SUM;
         ST_SUM:   state_in = ST_DIV;
         ST_DIV:   if (stage_last) state_in = ST_POS;
         ST_POS:   if (stage_last) state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: first cycle of a stage loads, the rest shift
   always_comb begin
      mod_ctrl  = '0;
      mul1_ctrl = '0;
      mul2_ctrl = '0;
      div_ctrl  = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            stage_len = '0;
            req_stall = 1'b0;
         end
         ST_ERR: begin
            stage_len     = CNT_W'(EMAG_W);
            mod_ctrl.load = (cnt_ff == '0);
            mod_ctrl.step = (cnt_ff != '0);
         end
         ST_RATE: begin
            stage_len      = CNT_W'(GAIN_W);
            mul1_ctrl.load = (cnt_ff == '0);
            mul1_ctrl.step = (cnt_ff != '0);
         end
         ST_SCALE: begin
            stage_len      = CNT_W'(DT_W);
            mul2_ctrl.load = (cnt_ff == '0);
            mul2_ctrl.step = (cnt_ff != '0);
         end
         ST_DIV: begin
            stage_len     = CNT_W'(ACCUM_WIDTH);
            div_ctrl.load = (cnt_ff == '0);
            div_ctrl.step = (cnt_ff != '0);
         end
         ST_POS: begin
            stage_len     = CNT_W'(EMAG_W);
            mod_ctrl.load = (cnt_ff == '0);
            mod_ctrl.step = (cnt_ff != '0);
         end
         default: begin
            stage_len = '0;
         end
      endcase
      stage_last = (cnt_ff == stage_len);
   end

   // stage counter and result handshake
   always_comb begin
      cnt_in       = stage_last ? '0 : cnt_ff + 1'b1;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers, configuration and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         gain_ff       <= GAIN_RST;
         max_rate_ff   <= MAX_RATE_RST;
         spr_ff        <= STEPS_PER_REV_RST;
         max_pulses_ff <= MAX_PULSES_RST;
         cur_ff        <= '0;
         acc_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GAIN:          gain_ff       <= csr_wdata[GAIN_W-1:0];
               CSR_MAX_RATE:      max_rate_ff   <= csr_wdata[RATE_W-1:0];
               CSR_STEPS_PER_REV: spr_ff        <= csr_wdata[POS_W-1:0];
               CSR_MAX_PULSES:    max_pulses_ff <= csr_wdata[PULSE_W-1:0];
               default: ;
            endcase
         end
         if (div_ctrl.load == 1'b0 && state_ff == ST_POS && cnt_ff == '0) begin
            acc_ff <= sneg_ff ? -rem_ext : rem_ext;
         end
         if ((state_ff == ST_OUT) && out_free) begin
            cur_ff <= pos_new;
         end
      end
   end

   // per-item working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         err_mag_ff <= err_abs[EMAG_W-1:0];
         err_neg_ff <= err_raw[TGT_W+1];
         dt_ff      <= req_data.dt_us;
      end
      if (mul1_ctrl.load) begin
         rneg_ff <= err_neg_ff ^ wrap_over;
      end
      if (state_ff == ST_SUM) begin
         sum_ff <= sum_sat;
      end
      if (div_ctrl.load) begin
         sneg_ff <= sum_ff[ACCUM_WIDTH-1];
      end
      if ((state_ff == ST_POS) && mod_ctrl.load) begin
         vneg_ff  <= pos_sum[POS_W+1];
         dir_ff   <= dir_new;
         pulse_ff <= pulse_new;
      end
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_data_ff.direction   <= dir_ff;
         rsp_data_ff.pulse_count <= pulse_ff;
         rsp_data_ff.position    <= pos_new;
      end
   end

endmodule

`default_nettype wire

>>> rtl/spg_checker.sv
// port-level checks of the step generator, bound to the top level
// depends on spg_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "stepper_proportional_step_generator_unit_assert.svh"

module spg_checker
   import spg_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a held result beat keeps its payload
   `SPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // one item in flight: the input stalls right after a beat is taken
   `SPG_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)

   // a new result only appears at the end of an item's work
   `SPG_ASSERT_NOW(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall))

   // after reset nothing is held and the input is open
   `SPG_ASSERT_NOW(a_reset_clear, clock, 1'b0, $fell(reset), !rsp_valid && !req_stall)

endmodule

bind stepper_proportional_step_generator_unit spg_checker u_spg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/stepper_proportional_step_generator_unit_test.sv
// testbench of the proportional step generator: directed and random ticks against a predictor
// depends on spg_pkg and stepper_proportional_step_generator_unit
`timescale 1ns / 1ps

module stepper_proportional_step_generator_unit_test
   import spg_pkg::*;
();

   localparam int ACC_W       = 40;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 150;
   localparam int PHASE_TICKS = 275;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [CSR_AW-1:0] csr_index = CSR_GAIN;
   logic [CSR_DW-1:0] csr_wdata = '0;

   // register copy and axis state of the predictor
   logic [GAIN_W-1:0]        cfg_gain   = GAIN_RST;
   logic [RATE_W-1:0]        cfg_rate   = MAX_RATE_RST;
   logic [POS_W-1:0]         cfg_rev    = STEPS_PER_REV_RST;
   logic [PULSE_W-1:0]       cfg_pulses = MAX_PULSES_RST;
   logic [POS_W-1:0]         axis_pos   = '0;
   logic signed [ACC_W-1:0]  axis_accum = '0;

   rsp_type predicted_moves[$];
   int      mismatches   = 0;
   int      quiet_cycles = 0;
   bit      calm         = 1'b0;

   stepper_proportional_step_generator_unit #(.ACCUM_WIDTH(ACC_W)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // one control tick: wrap the error, scale and limit the rate, integrate, issue pulses
   function automatic rsp_type advance_axis(input req_type beat);
      longint  rev, err, rate, lim, sum, whole, mag, pos, amax;
      rsp_type move;
      rev  = (cfg_rev == 0) ? 1 : longint'(cfg_rev);
      err  = longint'($signed(beat.target_position)) - longint'(axis_pos);
      // error to half a revolution, the sign of the error keeps the boundary
      if (err >= 0) begin
         err = err % rev;
         if (2 * err > rev) err = err - rev;
      end else begin
         err = -((-err) % rev);
         if (2 * err < -rev) err = err + rev;
      end
      rate = longint'(cfg_gain) * err;
      lim  = longint'(cfg_rate) * 16;
      if (rate > lim) rate = lim;
      if (rate < -lim) rate = -lim;
      amax = (longint'(1) << (ACC_W - 1)) - 1;
      sum  = longint'(axis_accum) + rate * longint'(beat.dt_us);
      if (sum > amax) sum = amax;
      if (sum < -amax - 1) sum = -amax - 1;
      // whole steps truncate toward zero, the rest stays behind
      whole      = sum / longint'(UNITS_PER_STEP);
      axis_accum = ACC_W'(sum - whole * longint'(UNITS_PER_STEP));
      move.direction = (whole > 0);
      mag = (whole < 0) ? -whole : whole;
      if (mag > longint'(cfg_pulses)) mag = longint'(cfg_pulses);
      pos = (longint'(axis_pos) + (move.direction ? mag : -mag)) % rev;
      if (pos < 0) pos = pos + rev;
      axis_pos         = pos[POS_W-1:0];
      move.pulse_count = mag[PULSE_W-1:0];
      move.position    = axis_pos;
      return move;
   endfunction

   task automatic flag_mismatch(input string what, input int want, input int got);
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
      mismatches++;
   endtask

   // sample both channels at the edge: predict on input beats, check result beats
   always @(posedge clock) begin : sample_beats
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted_moves.insert(predicted_moves.size(), advance_axis(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_moves.size() == 0) begin
               flag_mismatch("result with nothing pending, position", -1, rsp_data.position);
            end else begin
               want = predicted_moves[0];
               predicted_moves.delete(0);
               if (rsp_data.direction !== want.direction)
                  flag_mismatch("direction", want.direction, rsp_data.direction);
               if (rsp_data.pulse_count !== want.pulse_count)
                  flag_mismatch("pulse_count", want.pulse_count, rsp_data.pulse_count);
               if (rsp_data.position !== want.position)
                  flag_mismatch("position", want.position, rsp_data.position);
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) rsp_stall <= !calm && ($urandom_range(99) < 26);

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic req_type make_tick(input int target, input int dt);
      req_type beat;
      beat.target_position = target[TGT_W-1:0];
      beat.dt_us           = dt[DT_W-1:0];
      return beat;
   endfunction

   task automatic send_tick(input req_type beat);
      while (!calm && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // wait until every result is back and the block is idle
   task automatic settle();
      req_valid <= 1'b0;
      // let the sampler record a beat taken at the edge just passed
      @(posedge clock);
      while (predicted_moves.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // target given relative to the settled position
   task automatic send_relative(input int offset, input int dt);
      settle();
      send_tick(make_tick(int'(axis_pos) + offset, dt));
   endtask

   task automatic program_regs(input logic [GAIN_W-1:0] g, input logic [RATE_W-1:0] r,
                               input logic [POS_W-1:0] s, input logic [PULSE_W-1:0] p);
      settle();
      cfg_gain   = g;
      cfg_rate   = r;
      cfg_rev    = s;
      cfg_pulses = p;
      csr_wr_en <= 1'b1;
      csr_index <= CSR_GAIN;
      csr_wdata <= CSR_DW'(g);
      @(posedge clock);
      csr_index <= CSR_MAX_RATE;
      csr_wdata <= r;
      @(posedge clock);
      csr_index <= CSR_STEPS_PER_REV;
      csr_wdata <= CSR_DW'(s);
      @(posedge clock);
      csr_index <= CSR_MAX_PULSES;
      csr_wdata <= CSR_DW'(p);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // reset defaults: half-revolution boundaries, field extremes, no whole step
   task automatic test_error_wrap();
      send_relative(800, 50000);
      send_relative(-800, 50000);
      send_relative(801, 20000);
      send_relative(-801, 20000);
      send_relative(0, 30000);
      send_tick(make_tick(16383, 65535));
      send_tick(make_tick(-16384, 65535));
      send_tick(make_tick(16383, 0));
   endtask

   // zero rate limit, zero pulse limit with steps pending, zero revolution
   task automatic test_zero_limits();
      program_regs(8'd255, 16'd0, 14'd1600, 8'd50);
      send_relative(400, 50000);
      program_regs(8'd255, 16'd65535, 14'd1600, 8'd0);
      send_relative(300, 50000);
      send_relative(-300, 50000);
      program_regs(8'd80, 16'd2000, 14'd0, 8'd50);
      send_tick(make_tick(1234, 40000));
   endtask

   // large revolution, then a small one that leaves the position out of range, then zero gain and minimum limits
   task automatic test_shrunk_revolution();
      program_regs(8'd255, 16'd65535, 14'd12800, 8'd255);
      send_relative(6400, 50000);
      send_relative(-6400, 50000);
      send_relative(-300, 50000);
      program_regs(8'd255, 16'd65535, 14'd200, 8'd255);
      send_tick(make_tick(0, 0));
      send_tick(make_tick(-16384, 50000));
      program_regs(8'd0, 16'd65535, 14'd12800, 8'd255);
      send_relative(5000, 50000);
      program_regs(8'd1, 16'd1, 14'd200, 8'd1);
      send_relative(50, 65535);
   endtask

   function automatic req_type random_tick();
      int spr;
      int pick;
      spr  = (cfg_rev == 0) ? 1 : int'(cfg_rev);
      pick = $urandom_range(9);
      if (pick == 0)
         return make_tick($urandom, $urandom);
      if (pick == 1)
         return make_tick(int'($urandom_range(2 * spr)) - spr, $urandom_range(200));
      return make_tick(int'($urandom_range(2 * spr)) - spr, $urandom_range(50000));
   endfunction

   // random ticks over several register settings, one phase without idling
   task automatic test_random_ticks();
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               program_regs(GAIN_RST, MAX_RATE_RST, STEPS_PER_REV_RST, MAX_PULSES_RST);
               calm = 1'b1;
            end
            1: program_regs(8'd255, 16'd65535, 14'd12800, 8'd255);
            2: program_regs(8'd1, 16'd1, 14'd200, 8'd1);
            3: program_regs(GAIN_W'($urandom_range(255)), RATE_W'($urandom_range(65535)),
                            POS_W'($urandom_range(16383)), PULSE_W'($urandom_range(255)));
            default: program_regs(GAIN_W'($urandom_range(255)),
                                  RATE_W'($urandom_range(1, 65535)),
                                  POS_W'($urandom_range(200, 12800)),
                                  PULSE_W'($urandom_range(1, 255)));
         endcase
         for (int n = 0; n < PHASE_TICKS; n++) send_tick(random_tick());
         calm = 1'b0;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_error_wrap();
      test_zero_limits();
      test_shrunk_revolution();
      test_random_ticks();
      settle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (predicted_moves.size() != 0)
         flag_mismatch("results never returned", 0, predicted_moves.size());
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
